// ----- src/ips_pkg.sv -----
// ----------------------------------------------------------------------------
// ips_pkg: shared types and constants for the integer axis prefix sum
// Widths, register map and the item record passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package ips_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned INNER_MAX   = 1024;
  localparam int unsigned IDX_W       = $clog2(INNER_MAX);
  localparam int unsigned INNER_LEN_W = 11;
  localparam int unsigned COUNT_W     = 16;
  localparam int unsigned ADDR_W      = 4;
  localparam int unsigned QDEPTH      = 4;
  localparam int unsigned QPTR_W      = $clog2(QDEPTH);

  typedef enum logic [1:0] {
    REG_AXIS_LEN    = 2'd0,
    REG_INNER_LEN   = 2'd1,
    REG_OUTER_COUNT = 2'd2,
    REG_EXCLUSIVE   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [COUNT_W-1:0]     axis_len;
    logic [INNER_LEN_W-1:0] inner_len;
    logic [COUNT_W-1:0]     outer_count;
    logic                   exclusive_mode;
  } cfg_t;

  // One classified element, as queued between front and back.
  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [IDX_W-1:0]         idx;
    logic                     first_axis;
    logic                     slice_end;
    logic                     tensor_end;
  } item_t;

endpackage

`default_nettype wire

// ----- src/ips_regs.sv -----
// ----------------------------------------------------------------------------
// ips_regs: configuration register file
// APB-style write/read of the four scan registers; any valid write
// pulses a position clear so a new tensor starts.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_regs (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ips_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready,
  output ips_pkg::cfg_t                   cfg_o,
  output logic                            clear_o
);

  ips_pkg::cfg_t     cfg_q, cfg_d;
  ips_pkg::reg_idx_e idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = ips_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        ips_pkg::REG_AXIS_LEN:    cfg_d.axis_len       = pwdata[ips_pkg::COUNT_W-1:0];
        ips_pkg::REG_INNER_LEN:   cfg_d.inner_len      = pwdata[ips_pkg::INNER_LEN_W-1:0];
        ips_pkg::REG_OUTER_COUNT: cfg_d.outer_count    = pwdata[ips_pkg::COUNT_W-1:0];
        ips_pkg::REG_EXCLUSIVE:   cfg_d.exclusive_mode = pwdata[0];
        default:                  cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.axis_len       <= ips_pkg::COUNT_W'(1);
      cfg_q.inner_len      <= ips_pkg::INNER_LEN_W'(1);
      cfg_q.outer_count    <= ips_pkg::COUNT_W'(1);
      cfg_q.exclusive_mode <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (idx)
      ips_pkg::REG_AXIS_LEN:    prdata = 32'(cfg_q.axis_len);
      ips_pkg::REG_INNER_LEN:   prdata = 32'(cfg_q.inner_len);
      ips_pkg::REG_OUTER_COUNT: prdata = 32'(cfg_q.outer_count);
      ips_pkg::REG_EXCLUSIVE:   prdata = 32'(cfg_q.exclusive_mode);
      default:                  prdata = '0;
    endcase
  end

  assign cfg_o   = cfg_q;
  assign clear_o = wr_en;

endmodule

`default_nettype wire

// ----- src/ips_front.sv -----
// ----------------------------------------------------------------------------
// ips_front: input side
// Tracks inner/axis/outer positions of each request and tags it with
// its running-sum index and end-of-slice / end-of-tensor flags.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ips_pkg::cfg_t              cfg_i,
  input  wire logic                       clear_i,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [ips_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  input  wire logic                       q_full_i,
  output logic                            push_o,
  output ips_pkg::item_t                  item_o
);

  logic [ips_pkg::IDX_W-1:0]       inner_q, inner_d;
  logic [ips_pkg::COUNT_W-1:0]     axis_q, axis_d;
  logic [ips_pkg::COUNT_W-1:0]     outer_q, outer_d;
  logic [ips_pkg::INNER_LEN_W-1:0] n_inner;
  logic [ips_pkg::COUNT_W-1:0]     n_axis, n_outer;
  logic                            last_inner, last_axis, last_outer;

  // zero lengths act as one; inner length saturates at the store depth
  always_comb begin
    if (cfg_i.inner_len == '0) begin
      n_inner = ips_pkg::INNER_LEN_W'(1);
    end else if (cfg_i.inner_len > ips_pkg::INNER_LEN_W'(ips_pkg::INNER_MAX)) begin
      n_inner = ips_pkg::INNER_LEN_W'(ips_pkg::INNER_MAX);
    end else begin
      n_inner = cfg_i.inner_len;
    end
    n_axis  = (cfg_i.axis_len == '0)    ? ips_pkg::COUNT_W'(1) : cfg_i.axis_len;
    n_outer = (cfg_i.outer_count == '0) ? ips_pkg::COUNT_W'(1) : cfg_i.outer_count;
  end

  assign last_inner = ({1'b0, inner_q} + ips_pkg::INNER_LEN_W'(1)) >= n_inner;
  assign last_axis  = ({1'b0, axis_q} + 17'd1) >= {1'b0, n_axis};
  assign last_outer = ({1'b0, outer_q} + 17'd1) >= {1'b0, n_outer};

  assign s_axis_tready_o = ~q_full_i;
  assign push_o          = s_axis_tvalid_i & ~q_full_i;

  always_comb begin
    item_o.value      = s_axis_tdata_i;
    item_o.idx        = ({1'b0, inner_q} >= n_inner) ? '0 : inner_q;
    item_o.first_axis = (axis_q == '0);
    item_o.slice_end  = last_inner & last_axis;
    item_o.tensor_end = last_inner & last_axis & last_outer;
  end

  always_comb begin
    inner_d = inner_q;
    axis_d  = axis_q;
    outer_d = outer_q;
    if (clear_i) begin
      inner_d = '0;
      axis_d  = '0;
      outer_d = '0;
    end else if (push_o) begin
      if (!last_inner) begin
        inner_d = inner_q + 1'b1;
      end else begin
        inner_d = '0;
        if (!last_axis) begin
          axis_d = axis_q + 1'b1;
        end else begin
          axis_d  = '0;
          outer_d = last_outer ? '0 : outer_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q <= '0;
      axis_q  <= '0;
      outer_q <= '0;
    end else begin
      inner_q <= inner_d;
      axis_q  <= axis_d;
      outer_q <= outer_d;
    end
  end

endmodule

`default_nettype wire

// ----- src/ips_queue.sv -----
// ----------------------------------------------------------------------------
// ips_queue: short request queue between front and back
// Circular buffer; push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire ips_pkg::item_t push_item_i,
  input  wire logic           pop_i,
  output logic                full_o,
  output logic                valid_o,
  output ips_pkg::item_t      head_o
);

  localparam int unsigned CNT_W = $clog2(ips_pkg::QDEPTH + 1);

  ips_pkg::item_t              buf_q [ips_pkg::QDEPTH];
  logic [ips_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            cnt_q;

  assign full_o  = (cnt_q == CNT_W'(ips_pkg::QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- src/ips_back.sv -----
// ----------------------------------------------------------------------------
// ips_back: scan execution
// Reads the running sum at pop into a registered read, adds the element in
// the execute stage, writes the sum back and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ips_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       exclusive_i,
  input  wire logic                       q_valid_i,
  input  wire ips_pkg::item_t             q_head_i,
  output logic                            pop_o,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [ips_pkg::DATA_W-1:0]      m_axis_tdata_o,  // [31:0] sum
  output logic                            m_axis_tlast_o,  // slice_end
  output logic                            m_axis_tuser_o   // tensor_end
);

  logic [ips_pkg::DATA_W-1:0] mem_q [ips_pkg::INNER_MAX];
  logic [ips_pkg::DATA_W-1:0] rdata_q;
  logic [ips_pkg::DATA_W-1:0] wsum_q;
  ips_pkg::item_t             b_item_q;
  logic                       b_valid_q, b_fwd_q;
  logic                       o_valid_q, o_last_q, o_user_q;
  logic [ips_pkg::DATA_W-1:0] o_sum_q;

  logic                       b_adv;
  logic [ips_pkg::DATA_W-1:0] prior_sum, through;

  assign b_adv = b_valid_q & (~o_valid_q | m_axis_tready_i);
  assign pop_o = q_valid_i & (~b_valid_q | b_adv);

  // write of the item leaving now is not yet visible to the read issued
  // in the same cycle, so take its sum from the bypass register instead
  always_comb begin
    if (b_item_q.first_axis) begin
      prior_sum = '0;
    end else if (b_fwd_q) begin
      prior_sum = wsum_q;
    end else begin
      prior_sum = rdata_q;
    end
    through = prior_sum + b_item_q.value;
  end

  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      mem_q[b_item_q.idx] <= through;
    end
    if (pop_o) begin
      rdata_q <= mem_q[q_head_i.idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      b_item_q <= q_head_i;
      b_fwd_q  <= b_adv & (b_item_q.idx == q_head_i.idx);
    end
    if (b_adv) begin
      wsum_q   <= through;
      o_sum_q  <= exclusive_i ? prior_sum : through;
      o_last_q <= b_item_q.slice_end;
      o_user_q <= b_item_q.tensor_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
      if (b_adv) begin
        o_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid_o = o_valid_q;
  assign m_axis_tdata_o  = o_sum_q;
  assign m_axis_tlast_o  = o_last_q;
  assign m_axis_tuser_o  = o_user_q;

endmodule

`default_nettype wire

// ----- src/int_axis_prefix_sum.sv -----
// ----------------------------------------------------------------------------
// int_axis_prefix_sum: streaming cumulative sum of an int32 tensor
// Elements enter on s_axis in (outer, axis, inner) order; one result per
// element leaves on m_axis with tdata = wrapped 32-bit running sum,
// tlast = end of outer slice, tuser = end of tensor. exclusive_mode
// selects the sum before the element instead of through it; a reverse
// scan needs the feeder to send each slice from its end.
// Registers (APB, byte address 4*i): axis_len, inner_len, outer_count,
// exclusive_mode. Any register write restarts the tensor position.
// Throughput is one element per cycle while the receiver keeps tready
// high; an element passes the 4-entry request queue, then the registered
// read of the 1024-entry running-sum RAM, after which the sum lands in
// the output register. A stalled receiver holds the output register;
// the execute stage and the queue then fill (six requests in all) and
// s_axis_tready drops.
// Reset restores the register defaults (all lengths 1, inclusive) and
// empties the pipeline. The running-sum RAM is not cleared: an entry is
// always written at axis position 0 before its read value is used.
// ----------------------------------------------------------------------------
`default_nettype none

module int_axis_prefix_sum (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [ips_pkg::DATA_W-1:0] s_axis_tdata_i,  // [31:0] value
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [ips_pkg::DATA_W-1:0]      m_axis_tdata_o,  // [31:0] sum
  output logic                            m_axis_tlast_o,  // slice_end
  output logic                            m_axis_tuser_o,  // [0] tensor_end
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [ips_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                pwdata,
  output logic      [31:0]                prdata,
  output logic                            pready
);

  ips_pkg::cfg_t  cfg;
  logic           clear;
  logic           push, pop, q_full, q_valid;
  ips_pkg::item_t push_item, head_item;

  ips_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg),
    .clear_o (clear)
  );

  ips_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .clear_i         (clear),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  ips_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  ips_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .exclusive_i     (cfg.exclusive_mode),
    .q_valid_i       (q_valid),
    .q_head_i        (head_item),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for int_axis_prefix_sum
// Streams int32 elements through the block under a range of tensor shapes
// and both scan modes. A scoreboard class keeps its own running sums and
// position counters, queues the expected sum and end flags for each
// accepted element, and compares every returned result field by field.
// Sender and receiver idle at random; one long receiver hold-off forces
// the block to fill and stall its input.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned RANDOM_ITEMS = 600;

  typedef struct packed {
    logic [31:0] sum;
    logic        slice_end;
    logic        tensor_end;
  } scan_result_t;

  class prefix_sum_scoreboard;
    logic [31:0]      lane_sums [ips_pkg::INNER_MAX];
    int unsigned      lane, step, slice;
    logic [15:0]      axis_len;
    logic [10:0]      inner_len;
    logic [15:0]      outer_count;
    logic             exclusive;
    scan_result_t     expected_q [$];
    int unsigned      errors;

    function new();
      lane        = 0;
      step        = 0;
      slice       = 0;
      axis_len    = 16'd1;
      inner_len   = 11'd1;
      outer_count = 16'd1;
      exclusive   = 1'b0;
      errors      = 0;
    endfunction

    function void apply_write(ips_pkg::reg_idx_e r, logic [31:0] data);
      case (r)
        ips_pkg::REG_AXIS_LEN:    axis_len    = data[15:0];
        ips_pkg::REG_INNER_LEN:   inner_len   = data[10:0];
        ips_pkg::REG_OUTER_COUNT: outer_count = data[15:0];
        ips_pkg::REG_EXCLUSIVE:   exclusive   = data[0];
        default: ;
      endcase
      // any write starts a fresh tensor
      lane  = 0;
      step  = 0;
      slice = 0;
    endfunction

    function void note_input(logic [31:0] elem);
      int unsigned  n_axis, n_inner, n_outer;
      logic [31:0]  prior, through;
      logic         last_lane, last_step, last_slice;
      scan_result_t want;
      n_axis  = (axis_len == 0) ? 1 : axis_len;
      n_inner = (inner_len == 0) ? 1 :
                ((inner_len > ips_pkg::INNER_MAX) ? ips_pkg::INNER_MAX : inner_len);
      n_outer = (outer_count == 0) ? 1 : outer_count;
      prior   = (step == 0) ? 32'd0 : lane_sums[lane];
      through = prior + elem;
      lane_sums[lane] = through;
      last_lane  = (lane + 1 >= n_inner);
      last_step  = (step + 1 >= n_axis);
      last_slice = (slice + 1 >= n_outer);
      want.sum        = exclusive ? prior : through;
      want.slice_end  = last_lane && last_step;
      want.tensor_end = last_lane && last_step && last_slice;
      expected_q.push_back(want);
      if (!last_lane) begin
        lane++;
      end else begin
        lane = 0;
        if (!last_step) begin
          step++;
        end else begin
          step  = 0;
          slice = last_slice ? 0 : slice + 1;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    task report_mismatch(string what);
      $display("tb: mismatch: %s", what);
      errors++;
    endtask

    task check_result(logic [31:0] sum, logic slice_end, logic tensor_end);
      scan_result_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, sum=%h", sum));
        return;
      end
      want = expected_q.pop_front();
      if (sum !== want.sum)
        report_mismatch($sformatf("sum %h, expected %h", sum, want.sum));
      if (slice_end !== want.slice_end)
        report_mismatch($sformatf("slice_end %b, expected %b", slice_end, want.slice_end));
      if (tensor_end !== want.tensor_end)
        report_mismatch($sformatf("tensor_end %b, expected %b", tensor_end,
                                  want.tensor_end));
    endtask
  endclass

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic [31:0] s_axis_tdata  = '0;
  logic        m_axis_tready = 1'b0;
  logic        psel          = 1'b0;
  logic        penable       = 1'b0;
  logic        pwrite        = 1'b0;
  logic [ips_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata        = '0;

  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [31:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;
  logic        m_axis_tuser_o;
  logic [31:0] prdata;
  logic        pready;

  prefix_sum_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_pending  = 1'b0;

  int_axis_prefix_sum uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata),    // [31:0] value
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),  // [31:0] sum
    .m_axis_tlast_o  (m_axis_tlast_o),  // slice_end
    .m_axis_tuser_o  (m_axis_tuser_o),  // [0] tensor_end
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  task automatic write_reg(input ips_pkg::reg_idx_e r, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    sb.apply_write(r, data);
  endtask

  task automatic send_value(input logic [31:0] elem);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= elem;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(elem);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'($signed($urandom_range(20)) - 10);
      default: return $urandom;
    endcase
  endfunction

  // result side: checks at each accepting edge, then picks next tready
  initial begin
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_axis_tready)
        sb.check_result(m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
      if (hold_pending) begin
        hold_left    = HOLD_CYCLES;
        hold_pending = 1'b0;
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // watchdog: ends the run once nothing moves for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready) || psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin
    int unsigned random_sent, n_items, shape;
    int unsigned ax, inn, oc;
    bit          held;
    random_sent = 0;
    held        = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // defaults after reset: every element is a whole tensor
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'hFFFF_FFFF);
    wait_idle();

    // 2 x 2 x 2 inclusive; lane 0 wraps past the top
    write_reg(ips_pkg::REG_AXIS_LEN, 32'd2);
    write_reg(ips_pkg::REG_INNER_LEN, 32'h0001_0002);  // upper bits beyond the field are dropped
    write_reg(ips_pkg::REG_OUTER_COUNT, 32'd2);
    write_reg(ips_pkg::REG_EXCLUSIVE, 32'd0);
    send_value(32'h7FFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd1);
    wait_idle();

    // mid-slice write restarts the tensor, now exclusive
    write_reg(ips_pkg::REG_EXCLUSIVE, 32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h7FFF_FFFF);
    send_value(32'd0);
    send_value(32'h8000_0000);
    send_value(32'd5);
    send_value(32'h8000_0000);
    wait_idle();

    // zero lengths behave as one
    write_reg(ips_pkg::REG_AXIS_LEN, 32'd0);
    write_reg(ips_pkg::REG_INNER_LEN, 32'd0);
    write_reg(ips_pkg::REG_OUTER_COUNT, 32'd0);
    send_value(32'd7);
    send_value(32'hFFFF_FFF0);
    wait_idle();

    // longest axis and outer count
    write_reg(ips_pkg::REG_AXIS_LEN, 32'hFFFF);
    write_reg(ips_pkg::REG_INNER_LEN, 32'd2);
    write_reg(ips_pkg::REG_OUTER_COUNT, 32'hFFFF);
    write_reg(ips_pkg::REG_EXCLUSIVE, 32'd0);
    repeat (4) send_value(pick_value());
    wait_idle();
    write_reg(ips_pkg::REG_AXIS_LEN, 32'd1);
    write_reg(ips_pkg::REG_INNER_LEN, 32'd1);
    repeat (4) send_value(pick_value());
    wait_idle();

    while (random_sent < RANDOM_ITEMS) begin
      if (random_sent < RANDOM_ITEMS / 3) begin
        send_idle_pct = 10;
        recv_idle_pct = 60;
      end else if (random_sent < 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 60;
        recv_idle_pct = 10;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ax  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6);
      inn = ($urandom_range(9) == 0) ? 0 :
            (($urandom_range(7) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 5));
      oc  = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 4);
      // a skipped register keeps its value; with no write the tensor carries on
      if ($urandom_range(3) != 0) write_reg(ips_pkg::REG_AXIS_LEN, ax);
      if ($urandom_range(3) != 0) write_reg(ips_pkg::REG_INNER_LEN, inn);
      if ($urandom_range(3) != 0) write_reg(ips_pkg::REG_OUTER_COUNT, oc);
      if ($urandom_range(3) != 0) write_reg(ips_pkg::REG_EXCLUSIVE, $urandom_range(1));
      shape = ((sb.axis_len == 0) ? 1 : sb.axis_len)
            * ((sb.inner_len == 0) ? 1 : sb.inner_len)
            * ((sb.outer_count == 0) ? 1 : sb.outer_count);
      if (shape > 60)
        n_items = $urandom_range(1, 60);
      else if ($urandom_range(3) != 0)
        n_items = shape * $urandom_range(1, 2);
      else
        n_items = $urandom_range(1, shape);
      if (!held && random_sent >= 2 * RANDOM_ITEMS / 3) begin
        // long receiver hold-off while the sender keeps pushing
        held         = 1'b1;
        hold_pending = 1'b1;
        if (n_items < 40) n_items = 40;
      end
      repeat (n_items) send_value(pick_value());
      random_sent += n_items;
      wait_idle();
    end

    // inner length above the lane count saturates at the store depth
    write_reg(ips_pkg::REG_INNER_LEN, 32'd2047);
    write_reg(ips_pkg::REG_AXIS_LEN, 32'd2);
    write_reg(ips_pkg::REG_OUTER_COUNT, 32'd1);
    write_reg(ips_pkg::REG_EXCLUSIVE, $urandom_range(1));
    repeat (40) send_value(pick_value());
    wait_idle();

    if (sb.pending() != 0)
      sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
    if (sb.errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
